// File: rtl/fcbp_pkg.sv
// Shared types and constants for the framed command byte parser.
// No dependencies; used by framed_command_byte_parser.
`default_nettype none

package fcbp_pkg;

  localparam logic [7:0] START_BYTE       = 8'hAA;
  localparam logic [7:0] END_BYTE         = 8'h55;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

  typedef enum logic [1:0] {
    CODE_NOP      = 2'd0,
    CODE_LAMP_ON  = 2'd1,
    CODE_LAMP_OFF = 2'd2,
    CODE_LAMP_FLIP = 2'd3
  } command_code_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMD  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4,
    PH_END  = 3'd5
  } phase_t;

endpackage

`default_nettype wire

// File: rtl/framed_command_byte_parser.sv
// Framed command byte parser: frame hunting, length check, XOR checksum and
// command decode in one module. Depends on fcbp_pkg.
//
// Usage:
//   Input channel (in_valid, rx_byte, in_stall) carries one received byte per
//   beat. Output channel (out_valid, command_code, frame_accepted, out_stall)
//   carries exactly one result per input beat: command_code 1/2/3 with
//   frame_accepted high when a checked frame with a known command ends on
//   that byte, else zeros.
//   The configuration register max_frame_length is written through
//   cfg_write_en / cfg_write_data; the user must write it only while the
//   block is idle, which the block does not enforce. It is applied at the
//   next length byte. The result of a byte is registered and appears in the
//   cycle after it is accepted. The block takes one byte per cycle unless
//   the receiver stalls; frame state and result update in the same cycle.
//   When the receiver stalls, the result register holds its beat and
//   in_stall is raised, so no new byte is taken until the result drains.
//   Reset (rst, synchronous) returns to hunting for the start byte, empties
//   the result register and sets the length limit to 64.
`default_nettype none

module framed_command_byte_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      command_code,
  output logic            frame_accepted,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data
);

  fcbp_pkg::phase_t phase, phase_next;
  logic [7:0] max_frame_length;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] command_byte, command_byte_next;
  fcbp_pkg::command_code_t code;
  logic       accept;
  logic [7:0] count_inc;
  logic [8:0] count_reach;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign count_inc   = payload_count + 8'd1;
  assign count_reach = {1'b0, count_inc} + 9'd1;

  // Next frame state for the byte on rx_byte.
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    command_byte_next  = command_byte;
    unique case (phase)
      fcbp_pkg::PH_LEN: begin
        if (rx_byte == 8'd0 || rx_byte > max_frame_length) begin
          phase_next = fcbp_pkg::PH_HUNT;
        end else begin
          frame_length_next  = rx_byte;
          payload_count_next = 8'd0;
          running_xor_next   = rx_byte;
          phase_next         = fcbp_pkg::PH_CMD;
        end
      end
      fcbp_pkg::PH_CMD: begin
        command_byte_next = rx_byte;
        running_xor_next  = running_xor ^ rx_byte;
        phase_next = (frame_length > 8'd1) ? fcbp_pkg::PH_DATA : fcbp_pkg::PH_SUM;
      end
      fcbp_pkg::PH_DATA: begin
        payload_count_next = count_inc;
        running_xor_next   = running_xor ^ rx_byte;
        if (count_reach >= {1'b0, frame_length}) begin
          phase_next = fcbp_pkg::PH_SUM;
        end
      end
      fcbp_pkg::PH_SUM: begin
        phase_next = (running_xor == rx_byte) ? fcbp_pkg::PH_END : fcbp_pkg::PH_HUNT;
      end
      fcbp_pkg::PH_END: begin
        phase_next = fcbp_pkg::PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == fcbp_pkg::START_BYTE) ? fcbp_pkg::PH_LEN
                                                       : fcbp_pkg::PH_HUNT;
      end
    endcase
  end

  // Result for the byte on rx_byte.
  always_comb begin
    code = fcbp_pkg::CODE_NOP;
    if (phase == fcbp_pkg::PH_END && rx_byte == fcbp_pkg::END_BYTE &&
        command_byte >= 8'd1 && command_byte <= 8'd3) begin
      code = fcbp_pkg::command_code_t'(command_byte[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= fcbp_pkg::PH_HUNT;
      frame_length     <= 8'd0;
      payload_count    <= 8'd0;
      running_xor      <= 8'd0;
      command_byte     <= 8'd0;
      max_frame_length <= fcbp_pkg::MAX_LENGTH_RESET;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        max_frame_length <= cfg_write_data;
      end
      if (accept) begin
        phase         <= phase_next;
        frame_length  <= frame_length_next;
        payload_count <= payload_count_next;
        running_xor   <= running_xor_next;
        command_byte  <= command_byte_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result payload only needs to load when a byte is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      command_code   <= code;
      frame_accepted <= (code != fcbp_pkg::CODE_NOP);
    end
  end

`ifndef SYNTHESIS
  a_flag_matches_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_accepted == (command_code != fcbp_pkg::CODE_NOP)))
    else $error("frame_accepted disagrees with command_code");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_bad_sum_rehunts: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == fcbp_pkg::PH_SUM && rx_byte != running_xor)
      |=> (phase == fcbp_pkg::PH_HUNT))
    else $error("checksum mismatch did not return to hunting");

  a_accept_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != fcbp_pkg::PH_END) |=> !frame_accepted)
    else $error("frame accepted outside the end byte");
`endif

endmodule

`default_nettype wire
